// File: hw/rtl/ntfsrl_pkg.sv
// Shared widths, constants, register indexes and the run record type for the run-list decoder.
package ntfsrl_pkg;

  localparam int DATA_W     = 64;
  localparam int HALF_W     = 32;
  localparam int BYTE_W     = 8;
  localparam int NIB_W      = 4;
  localparam int LANES      = DATA_W / BYTE_W;
  localparam int LANE_IDX_W = $clog2(LANES);

  localparam int BPC_W      = 22;
  localparam int PSS_W      = 32;
  localparam int CFG_DATA_W = 32;
  localparam int CFG_IDX_W  = 1;

  localparam int SECTOR_BYTES_DEFAULT = 512;

  localparam logic [BYTE_W-1:0] LEN_NIB_MASK = 8'h0F;
  localparam logic [BYTE_W-1:0] OFF_NIB_MASK = 8'hF0;
  localparam logic [NIB_W-1:0]  MAX_FIELD_BYTES = 4'd8;

  localparam logic [BPC_W-1:0] BPC_RESET = 22'd4096;
  localparam logic [PSS_W-1:0] PSS_RESET = 32'd0;

  localparam logic [CFG_IDX_W-1:0] CFG_BYTES_PER_CLUSTER      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_PARTITION_START_SECTOR = 1'd1;

  // One decoded run (or list terminator) handed from the parser to the scaler.
  typedef struct packed {
    logic [DATA_W-1:0] clusters;
    logic [DATA_W-1:0] cluster_number;
    logic              list_end;
    logic              format_error;
  } run_t;

endpackage

// File: hw/rtl/ntfsrl_parser.sv
// Header/length/offset byte parser with cluster accumulation and a registered run record.
module ntfsrl_parser import ntfsrl_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [BYTE_W-1:0] run_byte,
  output logic              run_valid,
  output run_t              run,
  input  logic              run_ready
);

  typedef enum logic [1:0] {PH_HEADER, PH_LENGTH, PH_OFFSET} phase_t;

  phase_t            phase;
  logic [NIB_W-1:0]  len_size;
  logic [NIB_W-1:0]  off_size;
  logic [NIB_W-1:0]  cnt;
  logic [DATA_W-1:0] len_acc;
  logic [DATA_W-1:0] off_acc;
  logic [DATA_W-1:0] cur_cluster;

  logic              accept;
  logic              run_emit;
  logic [NIB_W-1:0]  lo_nib;
  logic [NIB_W-1:0]  hi_nib;
  logic [NIB_W-1:0]  cnt_inc;
  logic [DATA_W-1:0] shifted;
  logic [DATA_W-1:0] len_acc_next;
  logic [DATA_W-1:0] off_acc_next;
  logic [DATA_W-1:0] delta;
  logic [DATA_W-1:0] cluster_next;
  logic              sign;

  assign accept   = in_valid && !in_stall;
  assign in_stall = run_valid && !run_ready;
  assign lo_nib   = NIB_W'(run_byte & LEN_NIB_MASK);
  assign hi_nib   = NIB_W'((run_byte & OFF_NIB_MASK) >> NIB_W);
  assign cnt_inc  = cnt + 1'b1;
  assign shifted  = DATA_W'(run_byte) << (BYTE_W * cnt[LANE_IDX_W-1:0]);

  always_comb begin
    len_acc_next = len_acc;
    off_acc_next = off_acc;
    if (phase == PH_LENGTH) len_acc_next = len_acc | shifted;
    if (phase == PH_OFFSET) off_acc_next = off_acc | shifted;

    // sign of the offset field comes from bit 7 of its top byte
    sign = 1'b0;
    for (int i = 0; i < LANES; i++) begin
      if (off_size == NIB_W'(i + 1) && off_acc_next[BYTE_W*i + BYTE_W - 1]) sign = 1'b1;
    end
    delta = off_acc_next;
    for (int i = 0; i < LANES; i++) begin
      if (off_size != '0 && NIB_W'(i) >= off_size) delta[BYTE_W*i +: BYTE_W] = {BYTE_W{sign}};
    end
    cluster_next = cur_cluster + delta;

    // a record leaves on the last byte of a run or on a terminating header
    unique case (phase)
      PH_LENGTH: run_emit = accept && cnt_inc >= len_size && off_size == '0;
      PH_OFFSET: run_emit = accept && cnt_inc >= off_size;
      default:   run_emit = accept && (run_byte == '0 || lo_nib > MAX_FIELD_BYTES ||
                                       hi_nib > MAX_FIELD_BYTES);
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase       <= PH_HEADER;
      len_size    <= '0;
      off_size    <= '0;
      cnt         <= '0;
      len_acc     <= '0;
      off_acc     <= '0;
      cur_cluster <= '0;
      run_valid   <= 1'b0;
    end else begin
      if (run_emit) run_valid <= 1'b1;
      else if (run_ready) run_valid <= 1'b0;
      if (accept) begin
        unique case (phase)
          PH_LENGTH: begin
            len_acc <= len_acc_next;
            if (cnt_inc >= len_size) begin
              cnt <= '0;
              if (off_size == '0) begin
                phase              <= PH_HEADER;
                cur_cluster        <= cluster_next;
                run.clusters       <= len_acc_next;
                run.cluster_number <= cluster_next;
                run.list_end       <= 1'b0;
                run.format_error   <= 1'b0;
              end else begin
                phase <= PH_OFFSET;
              end
            end else begin
              cnt <= cnt_inc;
            end
          end
          PH_OFFSET: begin
            off_acc <= off_acc_next;
            if (cnt_inc >= off_size) begin
              cnt                <= '0;
              phase              <= PH_HEADER;
              cur_cluster        <= cluster_next;
              run.clusters       <= len_acc_next;
              run.cluster_number <= cluster_next;
              run.list_end       <= 1'b0;
              run.format_error   <= 1'b0;
            end else begin
              cnt <= cnt_inc;
            end
          end
          default: begin
            phase <= PH_HEADER;
            if (run_byte == '0) begin
              // end of list
              cur_cluster        <= '0;
              run.clusters       <= '0;
              run.cluster_number <= '0;
              run.list_end       <= 1'b1;
              run.format_error   <= 1'b0;
            end else if (lo_nib > MAX_FIELD_BYTES || hi_nib > MAX_FIELD_BYTES) begin
              cur_cluster        <= '0;
              cnt                <= '0;
              run.clusters       <= '0;
              run.cluster_number <= '0;
              run.list_end       <= 1'b1;
              run.format_error   <= 1'b1;
            end else begin
              len_size <= lo_nib;
              off_size <= hi_nib;
              cnt      <= '0;
              len_acc  <= '0;
              off_acc  <= '0;
              phase    <= (lo_nib != '0) ? PH_LENGTH : PH_OFFSET;
            end
          end
        endcase
      end
    end
  end

endmodule

// File: hw/rtl/ntfsrl_scaler.sv
// Two-stage cluster-to-byte scaling: split 32-bit partial products, then sum into the result register.
module ntfsrl_scaler import ntfsrl_pkg::*; #(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  input  logic [BPC_W-1:0]         bytes_per_cluster,
  input  logic [PSS_W-1:0]         partition_start_sector,
  input  logic                     run_valid,
  input  run_t                     run,
  output logic                     run_ready,
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DATA_W-1:0]        run_clusters,
  output logic signed [DATA_W-1:0] run_cluster_number,
  output logic [DATA_W-1:0]        disk_byte_offset,
  output logic [DATA_W-1:0]        run_byte_length,
  output logic                     list_end,
  output logic                     format_error
);

  localparam int SB_W   = $clog2(SECTOR_BYTES + 1);
  localparam int PROD_W = HALF_W + BPC_W;
  localparam int BASE_W = PSS_W + SB_W;

  logic              mid_valid;
  run_t              mid_run;
  logic [PROD_W-1:0] cl_lo_p;
  logic [HALF_W-1:0] cl_hi_p;
  logic [PROD_W-1:0] len_lo_p;
  logic [HALF_W-1:0] len_hi_p;
  logic [DATA_W-1:0] base;

  logic              out_ready;
  logic              mid_ready;
  logic [BASE_W-1:0] base_full;

  assign out_ready = !out_valid || !out_stall;
  assign mid_ready = !mid_valid || out_ready;
  assign run_ready = mid_ready;
  assign base_full = partition_start_sector * SB_W'(SECTOR_BYTES);

  always_ff @(posedge clk) begin
    if (rst) begin
      mid_valid <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (mid_ready) begin
        mid_valid <= run_valid;
        if (run_valid) begin
          mid_run  <= run;
          cl_lo_p  <= run.cluster_number[HALF_W-1:0] * bytes_per_cluster;
          cl_hi_p  <= run.cluster_number[DATA_W-1:HALF_W] * HALF_W'(bytes_per_cluster);
          len_lo_p <= run.clusters[HALF_W-1:0] * bytes_per_cluster;
          len_hi_p <= run.clusters[DATA_W-1:HALF_W] * HALF_W'(bytes_per_cluster);
          base     <= DATA_W'(base_full);
        end
      end
      if (out_ready) begin
        out_valid <= mid_valid;
        if (mid_valid) begin
          run_clusters       <= mid_run.clusters;
          run_cluster_number <= $signed(mid_run.cluster_number);
          // terminators carry no disk position
          if (mid_run.list_end) begin
            disk_byte_offset <= '0;
          end else begin
            disk_byte_offset <= {cl_hi_p, {HALF_W{1'b0}}} + DATA_W'(cl_lo_p) + base;
          end
          run_byte_length    <= {len_hi_p, {HALF_W{1'b0}}} + DATA_W'(len_lo_p);
          list_end           <= mid_run.list_end;
          format_error       <= mid_run.format_error;
        end
      end
    end
  end

endmodule

// File: hw/rtl/ntfs_run_list_decoder_core.sv
// Top level of the data-run list decoder: configuration registers, parser and scaler.
// Throughput: one run-list byte per cycle, every cycle, while out_stall is low.
// Path: a run's last byte (or a terminating header) passes through the parser record,
//   partial-product and result registers before out_valid rises.
// The two 32x22 multiplies per product sit in the scaler's first stage.
// Synchronous reset clears the parse state, the running cluster number and all valids,
//   and sets bytes_per_cluster to 4096 and partition_start_sector to 0.
module ntfs_run_list_decoder_core import ntfsrl_pkg::*; #(
  parameter int SECTOR_BYTES = SECTOR_BYTES_DEFAULT
) (
  input  logic                     clk,
  input  logic                     rst,
  // configuration write port
  input  logic                     cfg_write,
  input  logic [CFG_IDX_W-1:0]     cfg_index,
  input  logic [CFG_DATA_W-1:0]    cfg_data,
  // run-list byte stream
  input  logic                     in_valid,
  output logic                     in_stall,
  input  logic [BYTE_W-1:0]        run_byte,
  // decoded runs
  output logic                     out_valid,
  input  logic                     out_stall,
  output logic [DATA_W-1:0]        run_clusters,
  output logic signed [DATA_W-1:0] run_cluster_number,
  output logic [DATA_W-1:0]        disk_byte_offset,
  output logic [DATA_W-1:0]        run_byte_length,
  output logic                     list_end,
  output logic                     format_error
);

  logic [BPC_W-1:0] bytes_per_cluster;
  logic [PSS_W-1:0] partition_start_sector;

  logic run_valid;
  run_t run;
  logic run_ready;

  // Config only changes while the pipeline is empty, by the user's rule (not enforced); the scaler reads it directly.
  always_ff @(posedge clk) begin
    if (rst) begin
      bytes_per_cluster      <= BPC_RESET;
      partition_start_sector <= PSS_RESET;
    end else if (cfg_write) begin
      unique case (cfg_index)
        CFG_BYTES_PER_CLUSTER:      bytes_per_cluster      <= cfg_data[BPC_W-1:0];
        CFG_PARTITION_START_SECTOR: partition_start_sector <= cfg_data[PSS_W-1:0];
        default: ;
      endcase
    end
  end

  // Byte parser: tracks header/length/offset phases, sign-extends the offset
  // delta and keeps the running cluster number. One record per finished run or terminating header.
  ntfsrl_parser u_parser (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .run_byte  (run_byte),
    .run_valid (run_valid),
    .run       (run),
    .run_ready (run_ready)
  );

  // Scaler: cluster counts to byte offsets/lengths, wrapping mod 2^64.
  ntfsrl_scaler #(
    .SECTOR_BYTES (SECTOR_BYTES)
  ) u_scaler (
    .clk                    (clk),
    .rst                    (rst),
    .bytes_per_cluster      (bytes_per_cluster),
    .partition_start_sector (partition_start_sector),
    .run_valid              (run_valid),
    .run                    (run),
    .run_ready              (run_ready),
    .out_valid              (out_valid),
    .out_stall              (out_stall),
    .run_clusters           (run_clusters),
    .run_cluster_number     (run_cluster_number),
    .disk_byte_offset       (disk_byte_offset),
    .run_byte_length        (run_byte_length),
    .list_end               (list_end),
    .format_error           (format_error)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the run-list decoder: byte stream in, decoded runs scored.
module testbench;
  import ntfsrl_pkg::*;

  localparam int SECTOR       = SECTOR_BYTES_DEFAULT;
  localparam int CYCLE_LIMIT  = 400000;  // generous; a clean run needs far fewer
  localparam int SETTLE       = 10;      // covers the pipeline latency
  localparam int SHOWN_ERRORS = 10;

  // Parser phases of the decoder, mirrored in the local predictor.
  typedef enum logic [1:0] {AWAIT_HEADER, READ_LENGTH, READ_OFFSET} parse_phase_t;

  // One decoded run as it leaves the block.
  typedef struct {
    logic [DATA_W-1:0] clusters;
    logic [DATA_W-1:0] cluster_number;
    logic [DATA_W-1:0] disk_offset;
    logic [DATA_W-1:0] byte_length;
    logic              list_end;
    logic              format_error;
  } run_result_t;

  logic                     clk = 1'b0;
  logic                     rst = 1'b1;
  logic                     cfg_write = 1'b0;
  logic [CFG_IDX_W-1:0]     cfg_index = CFG_BYTES_PER_CLUSTER;
  logic [CFG_DATA_W-1:0]    cfg_data = '0;
  logic                     in_valid = 1'b0;
  logic                     in_stall;
  logic [BYTE_W-1:0]        run_byte = '0;
  logic                     out_valid;
  logic                     out_stall = 1'b0;
  logic [DATA_W-1:0]        run_clusters;
  logic signed [DATA_W-1:0] run_cluster_number;
  logic [DATA_W-1:0]        disk_byte_offset;
  logic [DATA_W-1:0]        run_byte_length;
  logic                     list_end;
  logic                     format_error;

  ntfs_run_list_decoder_core #(.SECTOR_BYTES(SECTOR)) uut (
    .clk(clk), .rst(rst),
    .cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .in_valid(in_valid), .in_stall(in_stall), .run_byte(run_byte),
    .out_valid(out_valid), .out_stall(out_stall),
    .run_clusters(run_clusters), .run_cluster_number(run_cluster_number),
    .disk_byte_offset(disk_byte_offset), .run_byte_length(run_byte_length),
    .list_end(list_end), .format_error(format_error)
  );

  always #5 clk = ~clk;

  // ---------------------------------------------------------------------------
  // Predictor state: a private copy of the parser and the two registers.
  // ---------------------------------------------------------------------------
  logic [BPC_W-1:0]  cluster_bytes = BPC_RESET;
  logic [PSS_W-1:0]  start_sector  = PSS_RESET;
  parse_phase_t      phase         = AWAIT_HEADER;
  logic [NIB_W-1:0]  len_size      = '0;
  logic [NIB_W-1:0]  off_size      = '0;
  logic [NIB_W-1:0]  field_pos     = '0;
  logic [DATA_W-1:0] len_acc       = '0;
  logic [DATA_W-1:0] off_acc       = '0;
  logic [DATA_W-1:0] lcn           = '0;

  run_result_t expected_runs[$];   // decoded runs still owed by the block

  int send_idle_pct  = 0;          // chance per transfer of a sender bubble
  int recv_stall_pct = 0;          // chance per cycle of output backpressure
  int mismatches     = 0;
  int cycle_count    = 0;

  // Last byte of a run: apply the signed delta and scale to disk bytes.
  function automatic void close_run();
    logic [DATA_W-1:0] delta;
    run_result_t r;
    delta = off_acc;
    // Fields of 1..7 bytes are sign-extended from their top byte;
    // an 8-byte field is already a full two's complement delta.
    if (off_size >= 1 && off_size <= 7) begin
      if (delta[8*off_size-1])
        delta |= ~((64'd1 << (8*off_size)) - 64'd1);
    end
    lcn += delta;
    r.clusters       = len_acc;
    r.cluster_number = lcn;
    r.disk_offset    = lcn * DATA_W'(cluster_bytes) + DATA_W'(start_sector) * DATA_W'(SECTOR);
    r.byte_length    = len_acc * DATA_W'(cluster_bytes);
    r.list_end       = 1'b0;
    r.format_error   = 1'b0;
    expected_runs.push_back(r);
    phase     = AWAIT_HEADER;
    field_pos = '0;
  endfunction

  // Terminating result: zero header or bad nibble; both restart the cluster count.
  function automatic void close_list(input logic bad_header);
    run_result_t r;
    r.clusters       = '0;
    r.cluster_number = '0;
    r.disk_offset    = '0;
    r.byte_length    = '0;
    r.list_end       = 1'b1;
    r.format_error   = bad_header;
    expected_runs.push_back(r);
    lcn = '0;
  endfunction

  // Advance the predictor by one transferred run-list byte.
  function automatic void decode_run_byte(input logic [BYTE_W-1:0] b);
    logic [NIB_W-1:0] l;
    logic [NIB_W-1:0] o;
    case (phase)
      READ_LENGTH: begin
        len_acc |= DATA_W'(b) << (8 * field_pos[2:0]);
        field_pos++;
        if (field_pos >= len_size) begin
          field_pos = '0;
          if (off_size == 0) close_run();
          else phase = READ_OFFSET;
        end
      end
      READ_OFFSET: begin
        off_acc |= DATA_W'(b) << (8 * field_pos[2:0]);
        field_pos++;
        if (field_pos >= off_size) close_run();
      end
      default: begin
        phase = AWAIT_HEADER;
        l = NIB_W'(b & LEN_NIB_MASK);
        o = NIB_W'((b & OFF_NIB_MASK) >> NIB_W);
        if (b == 0) begin
          close_list(1'b0);
        end else if (l > MAX_FIELD_BYTES || o > MAX_FIELD_BYTES) begin
          field_pos = '0;
          close_list(1'b1);
        end else begin
          len_size  = l;
          off_size  = o;
          field_pos = '0;
          len_acc   = '0;
          off_acc   = '0;
          phase     = (l != 0) ? READ_LENGTH : READ_OFFSET;
        end
      end
    endcase
  endfunction

  // ---------------------------------------------------------------------------
  // Drivers. Inputs move on the falling edge; handshakes are judged on the
  // rising edge, where in_stall still holds its pre-edge value.
  // ---------------------------------------------------------------------------
  always @(negedge clk) out_stall <= ($urandom_range(99) < recv_stall_pct);

  // One byte transfer, with optional bubbles ahead of it. valid stays high
  // between back-to-back transfers, so it is never dropped and raised in one step.
  task automatic send_run_byte(input logic [BYTE_W-1:0] b);
    while ($urandom_range(99) < send_idle_pct) begin
      @(negedge clk);
      in_valid <= 1'b0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1'b1;
    run_byte <= b;
    do @(posedge clk); while (in_stall);
    decode_run_byte(b);
  endtask

  // Sender holds off until every owed run has come out, then lets the pipe settle.
  task automatic wait_for_idle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (expected_runs.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  // Register write; only called with the pipe empty. Upper data bits are junk
  // on purpose: the block must drop what lies above the register width.
  task automatic write_register(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    if (idx == CFG_BYTES_PER_CLUSTER) cluster_bytes = value[BPC_W-1:0];
    else start_sector = value[PSS_W-1:0];
  endtask

  // A well-formed run: header plus little-endian length and offset bytes.
  task automatic send_run(input int lbytes, input int obytes);
    send_run_byte({4'(obytes), 4'(lbytes)});
    repeat (lbytes + obytes) send_run_byte(8'($urandom_range(255)));
  endtask

  // ---------------------------------------------------------------------------
  // Scoreboard: each output transfer against the oldest owed run.
  // ---------------------------------------------------------------------------
  task automatic compare_field(input string field, input logic [63:0] want,
                               input logic [63:0] got);
    if (want !== got) begin
      mismatches++;
      if (mismatches <= SHOWN_ERRORS)
        $display("%0d: %s expected %h got %h", cycle_count, field, want, got);
    end
  endtask

  always @(posedge clk) begin : result_check
    run_result_t want;
    if (!rst && out_valid && !out_stall) begin
      if (expected_runs.size() == 0) begin
        mismatches++;
        if (mismatches <= SHOWN_ERRORS)
          $display("%0d: result transfer with nothing owed (clusters %h lcn %h end %b err %b)",
                   cycle_count, run_clusters, run_cluster_number, list_end, format_error);
      end else begin
        want = expected_runs.pop_front();
        compare_field("run_clusters",       want.clusters,       run_clusters);
        compare_field("run_cluster_number", want.cluster_number, run_cluster_number);
        compare_field("disk_byte_offset",   want.disk_offset,    disk_byte_offset);
        compare_field("run_byte_length",    want.byte_length,    run_byte_length);
        compare_field("list_end",           64'(want.list_end),     64'(list_end));
        compare_field("format_error",       64'(want.format_error), 64'(format_error));
      end
    end
  end

  // Watchdog against a hung handshake.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Terminators: zero header, and a header nibble past 8 in each half.
  task automatic test_list_terminators();
    send_run_byte(8'h00);
    send_run(1, 1);
    send_run_byte(8'h09);          // bad length nibble
    send_run(1, 1);
    send_run_byte(8'hF0);          // bad offset nibble
    send_run_byte(8'h00);
  endtask

  // Field sizes: empty length, empty offset, negative short offset, full 8-byte fields.
  task automatic test_field_sizes();
    send_run_byte(8'h11); send_run_byte(8'hFF); send_run_byte(8'h80);  // 255 clusters, -128
    send_run_byte(8'h01); send_run_byte(8'h03);                        // keeps the lcn
    send_run_byte(8'h10); send_run_byte(8'h7F);                        // zero clusters
    send_run_byte(8'h88);                                              // both fields 8 bytes
    repeat (8) send_run_byte(8'hFF);
    repeat (7) send_run_byte(8'h00);
    send_run_byte(8'h80);
  endtask

  // Random lists: mostly well-formed runs, some terminators, bad headers and noise.
  task automatic test_random_lists(input int n_items, input int idle_pct, input int stall_pct);
    int sent;
    int pick;
    int l;
    int o;
    logic [BYTE_W-1:0] b;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent = 0;
    while (sent < n_items) begin
      pick = $urandom_range(99);
      if (pick < 72) begin
        do begin
          l = $urandom_range(8);
          o = $urandom_range(8);
        end while (l == 0 && o == 0);
        send_run(l, o);
        sent += 1 + l + o;
      end else if (pick < 82) begin
        send_run_byte(8'h00);
        sent++;
      end else if (pick < 89) begin
        do b = 8'($urandom_range(255));
        while (b[3:0] <= MAX_FIELD_BYTES && b[7:4] <= MAX_FIELD_BYTES);
        send_run_byte(b);
        sent++;
      end else begin
        // noise: raw bytes, parsed as whatever the current phase makes them
        repeat ($urandom_range(1, 4)) begin
          send_run_byte(8'($urandom_range(255)));
          sent++;
        end
      end
    end
  endtask

  // ---------------------------------------------------------------------------
  // Sequence
  // ---------------------------------------------------------------------------
  initial begin
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // reset register values first
    send_idle_pct  = 30;
    recv_stall_pct = 68;
    test_list_terminators();
    test_field_sizes();
    wait_for_idle();

    // smallest clusters, last partition sector
    write_register(CFG_BYTES_PER_CLUSTER, {10'($urandom_range(1023)), 22'd512});
    write_register(CFG_PARTITION_START_SECTOR, 32'hFFFF_FFFF);
    test_field_sizes();
    test_random_lists(260, 30, 68);
    wait_for_idle();

    // largest clusters, random partition start
    write_register(CFG_BYTES_PER_CLUSTER, {10'($urandom_range(1023)), 22'd2097152});
    write_register(CFG_PARTITION_START_SECTOR, 32'($urandom));
    test_random_lists(260, 68, 30);
    wait_for_idle();

    // a mid-range power-of-two cluster, partition at sector zero, full throughput
    write_register(CFG_BYTES_PER_CLUSTER, 32'(512 << $urandom_range(1, 11)));
    write_register(CFG_PARTITION_START_SECTOR, 32'd0);
    test_random_lists(260, 0, 0);
    wait_for_idle();

    // anything still owed never came out
    if (expected_runs.size() != 0) begin
      mismatches += expected_runs.size();
      $display("%0d runs never came out", expected_runs.size());
    end

    if (mismatches == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
